// File: hdl/fscs_pkg.sv
// ============================================================================
// fscs_pkg
// Shared types, sizes and codes of the flex sensor calibrate and scale block.
// ============================================================================
package fscs_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLES     = 30;
    localparam int SAMPLE_BITS = 10;
    localparam int ANGLE_BITS  = 8;
    localparam int TOL_BITS    = 10;
    localparam int SUM_BITS    = 16;
    localparam int COUNT_BITS  = 6;
    localparam int PROD_BITS   = SAMPLE_BITS + ANGLE_BITS;
    localparam int STEP_BITS   = $clog2(PROD_BITS);
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [TOL_BITS-1:0]   TOL_RESET  = TOL_BITS'(20);
    localparam logic [ANGLE_BITS-1:0] AMAX_RESET = ANGLE_BITS'(180);

    // Register index, taken from the word address.
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_ANGLE_MAX = 1'b1;

    // Phase codes as reported in phase_now.
    localparam logic [1:0] PH_OPEN  = 2'd0;
    localparam logic [1:0] PH_CLOSE = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [ANGLE_BITS-1:0]  t_angle;
    typedef logic [SUM_BITS-1:0]    t_sum;

    // Step controls that the sequencer sends to every lane in lockstep.
    typedef struct packed {
        logic load_map;
        logic load_avg;
        logic mul_step;
        logic div_step;
    } t_lane_ctl;

endpackage

// File: hdl/fscs_lane.sv
// ============================================================================
// fscs_lane
// Bit-serial shift-add multiplier and restoring divider for one channel.
// ============================================================================
module fscs_lane (
    input  logic                        i_clk,
    input  fscs_pkg::t_lane_ctl         i_ctl,
    input  fscs_pkg::t_sample           i_x,
    input  fscs_pkg::t_sample           i_lo,
    input  fscs_pkg::t_sample           i_hi,
    input  fscs_pkg::t_angle            i_amax,
    input  fscs_pkg::t_sum              i_sum,
    output fscs_pkg::t_angle            o_angle,
    output fscs_pkg::t_sample           o_avg
);

    // The product and then the dividend/quotient share one shift register.
    logic [fscs_pkg::PROD_BITS-1:0]   r_q;
    logic [fscs_pkg::SAMPLE_BITS-1:0] r_mcand;
    logic [fscs_pkg::SAMPLE_BITS-1:0] r_rem;
    logic [fscs_pkg::SAMPLE_BITS-1:0] r_dvs;
    logic                             r_force_zero;

    logic [fscs_pkg::SAMPLE_BITS:0]   w_diff;
    logic [fscs_pkg::SAMPLE_BITS:0]   w_span;
    logic [fscs_pkg::SAMPLE_BITS:0]   w_diff_mag;
    logic [fscs_pkg::SAMPLE_BITS:0]   w_span_mag;
    logic [fscs_pkg::SAMPLE_BITS:0]   w_mul_sum;
    logic [fscs_pkg::SAMPLE_BITS:0]   w_shifted;
    logic [fscs_pkg::SAMPLE_BITS+1:0] w_trial;

    always_comb begin
        w_diff     = {1'b0, i_x} - {1'b0, i_lo};
        w_span     = {1'b0, i_hi} - {1'b0, i_lo};
        w_diff_mag = w_diff[fscs_pkg::SAMPLE_BITS] ? -w_diff : w_diff;
        w_span_mag = w_span[fscs_pkg::SAMPLE_BITS] ? -w_span : w_span;
        w_mul_sum  = {1'b0, r_q[fscs_pkg::PROD_BITS-1:fscs_pkg::ANGLE_BITS]}
                   + (r_q[0] ? {1'b0, r_mcand} : '0);
        w_shifted  = {r_rem, r_q[fscs_pkg::PROD_BITS-1]};
        w_trial    = {1'b0, w_shifted} - {2'b00, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_map) begin
            r_q          <= {{fscs_pkg::SAMPLE_BITS{1'b0}}, i_amax};
            r_mcand      <= w_diff_mag[fscs_pkg::SAMPLE_BITS-1:0];
            r_rem        <= '0;
            r_dvs        <= w_span_mag[fscs_pkg::SAMPLE_BITS-1:0];
            // A zero span or a quotient of negative sign both end at zero.
            r_force_zero <= (i_hi == i_lo) ||
                            (w_diff[fscs_pkg::SAMPLE_BITS] ^ w_span[fscs_pkg::SAMPLE_BITS]);
        end else if (i_ctl.load_avg) begin
            r_q          <= fscs_pkg::PROD_BITS'(i_sum);
            r_rem        <= '0;
            r_dvs        <= fscs_pkg::SAMPLE_BITS'(fscs_pkg::SAMPLES);
            r_force_zero <= 1'b0;
        end else if (i_ctl.mul_step) begin
            r_q <= {w_mul_sum, r_q[fscs_pkg::ANGLE_BITS-1:1]};
        end else if (i_ctl.div_step) begin
            if (!w_trial[fscs_pkg::SAMPLE_BITS+1]) begin
                r_rem <= w_trial[fscs_pkg::SAMPLE_BITS-1:0];
                r_q   <= {r_q[fscs_pkg::PROD_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_shifted[fscs_pkg::SAMPLE_BITS-1:0];
                r_q   <= {r_q[fscs_pkg::PROD_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_force_zero) begin
            o_angle = '0;
        end else if (r_q > fscs_pkg::PROD_BITS'(i_amax)) begin
            o_angle = i_amax;
        end else begin
            o_angle = r_q[fscs_pkg::ANGLE_BITS-1:0];
        end
        o_avg = r_q[fscs_pkg::SAMPLE_BITS-1:0];
    end

endmodule

// File: hdl/flex_sensor_calibrate_and_scale.sv
// ============================================================================
// flex_sensor_calibrate_and_scale
// Two-point calibration of four sensor channels and linear map to angles.
// ============================================================================
// One sample set is taken at a time. A calibration set that is only checked
// against the reference or stored as reference goes from the evaluate state
// straight to the emit state; a set that completes a calibration phase also
// passes through the 18 steps of the bit-serial divider that forms the
// averages; a run-phase set passes through 8 shift-add multiply steps
// and 18 restoring divide steps in each channel lane (all lanes run together).
// A new set is taken as soon as the sequencer is idle, even while the last
// result still waits in the output register. After reset the block starts in
// open calibration: the first set becomes the reference, each of the next
// SAMPLES sets must lie strictly within tolerance of it on every channel,
// and a failing set raises tolerance_error and restarts the phase. Close
// calibration follows the same way, then every set is mapped so that the open
// average gives 0 and the close average gives angle_max, clamped to that
// range. The user must write the registers tolerance (address 0) and angle_max
// (address 4) over the APB port only while idle; the block does not enforce it.
// ============================================================================
module flex_sensor_calibrate_and_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Sample set input.
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  fscs_pkg::t_sample                    i_chan_a,
    input  fscs_pkg::t_sample                    i_chan_b,
    input  fscs_pkg::t_sample                    i_chan_c,
    input  fscs_pkg::t_sample                    i_chan_d,
    // Result output.
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output fscs_pkg::t_angle                     o_angle_a,
    output fscs_pkg::t_angle                     o_angle_b,
    output fscs_pkg::t_angle                     o_angle_c,
    output fscs_pkg::t_angle                     o_angle_d,
    output logic [1:0]                           o_phase_now,
    output logic                                 o_tolerance_error,
    output logic                                 o_angles_valid,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fscs_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [fscs_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [fscs_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_STORE,
        S_EMIT
    } t_state;

    t_state                              r_state;
    logic                                r_avg_mode;
    logic [fscs_pkg::STEP_BITS-1:0]      r_step;

    fscs_pkg::t_sample                   r_smp   [fscs_pkg::CHANNELS];
    fscs_pkg::t_sample                   r_ref   [fscs_pkg::CHANNELS];
    fscs_pkg::t_sum                      r_sum   [fscs_pkg::CHANNELS];
    fscs_pkg::t_sample                   r_open  [fscs_pkg::CHANNELS];
    fscs_pkg::t_sample                   r_close [fscs_pkg::CHANNELS];
    logic [1:0]                          r_phase;
    logic                                r_have_ref;
    logic [fscs_pkg::COUNT_BITS-1:0]     r_good;

    logic [fscs_pkg::TOL_BITS-1:0]       r_tol;
    fscs_pkg::t_angle                    r_amax;

    // Result as formed by the sequencer, before it moves to the output.
    fscs_pkg::t_angle                    r_res_angle [fscs_pkg::CHANNELS];
    logic [1:0]                          r_res_phase;
    logic                                r_res_err;
    logic                                r_res_valid;

    // Output register.
    logic                                r_out_valid;
    fscs_pkg::t_angle                    r_out_angle [fscs_pkg::CHANNELS];
    logic [1:0]                          r_out_phase;
    logic                                r_out_err;
    logic                                r_out_angles_valid;

    fscs_pkg::t_lane_ctl                 w_ctl;
    fscs_pkg::t_sum                      w_new_sum  [fscs_pkg::CHANNELS];
    fscs_pkg::t_angle                    w_lane_angle [fscs_pkg::CHANNELS];
    fscs_pkg::t_sample                   w_lane_avg [fscs_pkg::CHANNELS];
    fscs_pkg::t_sample                   w_dev      [fscs_pkg::CHANNELS];
    logic                                w_pass;
    logic [fscs_pkg::COUNT_BITS:0]       n_good;
    logic                                w_complete;
    logic                                w_cfg_write;

    // ------------------------------------------------------------------
    // Tolerance check and accumulation of the held sample set. Every
    // channel must lie strictly inside the tolerance for the set to pass.
    // ------------------------------------------------------------------
    always_comb begin
        w_pass = 1'b1;
        for (int c = 0; c < fscs_pkg::CHANNELS; c++) begin
            w_dev[c] = (r_smp[c] > r_ref[c]) ? (r_smp[c] - r_ref[c])
                                             : (r_ref[c] - r_smp[c]);
            if (!(fscs_pkg::TOL_BITS'(w_dev[c]) < r_tol)) begin
                w_pass = 1'b0;
            end
            w_new_sum[c] = r_sum[c] + fscs_pkg::SUM_BITS'(r_smp[c]);
        end
        n_good     = {1'b0, r_good} + 1'b1;
        w_complete = (n_good >= (fscs_pkg::COUNT_BITS + 1)'(fscs_pkg::SAMPLES));
    end

    // Lane step controls: the lanes only follow the sequencer state.
    always_comb begin
        w_ctl.load_map = (r_state == S_EVAL) && r_phase[1];
        w_ctl.load_avg = (r_state == S_EVAL) && !r_phase[1] && r_have_ref &&
                         w_pass && w_complete;
        w_ctl.mul_step = (r_state == S_MUL);
        w_ctl.div_step = (r_state == S_DIV);
    end

    for (genvar g = 0; g < fscs_pkg::CHANNELS; g++) begin : g_lane
        fscs_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_x     (r_smp[g]),
            .i_lo    (r_open[g]),
            .i_hi    (r_close[g]),
            .i_amax  (r_amax),
            .i_sum   (w_new_sum[g]),
            .o_angle (w_lane_angle[g]),
            .o_avg   (w_lane_avg[g])
        );
    end

    // ------------------------------------------------------------------
    // Configuration registers. The word address selects the register.
    // ------------------------------------------------------------------
    assign w_cfg_write = psel && penable && pwrite;
    assign pready      = 1'b1;

    always_comb begin
        case (paddr[2])
            fscs_pkg::REG_TOLERANCE:
                prdata = fscs_pkg::APB_DATA_BITS'(r_tol);
            fscs_pkg::REG_ANGLE_MAX:
                prdata = fscs_pkg::APB_DATA_BITS'(r_amax);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= fscs_pkg::TOL_RESET;
            r_amax <= fscs_pkg::AMAX_RESET;
        end else if (w_cfg_write) begin
            if (paddr[2] == fscs_pkg::REG_TOLERANCE) begin
                r_tol <= pwdata[fscs_pkg::TOL_BITS-1:0];
            end else begin
                r_amax <= pwdata[fscs_pkg::ANGLE_BITS-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, calibration state and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_avg_mode  <= 1'b0;
            r_step      <= '0;
            r_phase     <= fscs_pkg::PH_OPEN;
            r_have_ref  <= 1'b0;
            r_good      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output transaction frees the register, unless an emit
            // below refills it in the same cycle.
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_smp[0] <= i_chan_a;
                        r_smp[1] <= i_chan_b;
                        r_smp[2] <= i_chan_c;
                        r_smp[3] <= i_chan_d;
                        r_state  <= S_EVAL;
                    end
                end

                S_EVAL: begin
                    for (int c = 0; c < fscs_pkg::CHANNELS; c++) begin
                        r_res_angle[c] <= '0;
                    end
                    // Run phase; the unused phase code behaves the same.
                    r_res_err   <= !r_phase[1] && r_have_ref && !w_pass;
                    r_res_valid <= r_phase[1];
                    r_res_phase <= r_phase[1] ? fscs_pkg::PH_RUN : r_phase;
                    r_step      <= '0;
                    if (r_phase[1]) begin
                        r_avg_mode  <= 1'b0;
                        r_state     <= S_MUL;
                    end else if (!r_have_ref) begin
                        // The set becomes the reference and is not counted.
                        for (int c = 0; c < fscs_pkg::CHANNELS; c++) begin
                            r_ref[c] <= r_smp[c];
                            r_sum[c] <= '0;
                        end
                        r_have_ref <= 1'b1;
                        r_good     <= '0;
                        r_state    <= S_EMIT;
                    end else if (!w_pass) begin
                        // Drop the reference; the next set starts over.
                        r_have_ref <= 1'b0;
                        r_good     <= '0;
                        r_state    <= S_EMIT;
                    end else begin
                        for (int c = 0; c < fscs_pkg::CHANNELS; c++) begin
                            r_sum[c] <= w_new_sum[c];
                        end
                        r_good <= n_good[fscs_pkg::COUNT_BITS-1:0];
                        if (w_complete) begin
                            // The lanes divide the final sums by SAMPLES.
                            r_avg_mode <= 1'b1;
                            r_state    <= S_DIV;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end

                S_MUL: begin
                    if (r_step == fscs_pkg::STEP_BITS'(fscs_pkg::ANGLE_BITS - 1)) begin
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end

                S_DIV: begin
                    if (r_step == fscs_pkg::STEP_BITS'(fscs_pkg::PROD_BITS - 1)) begin
                        r_step  <= '0;
                        r_state <= S_STORE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end

                S_STORE: begin
                    if (r_avg_mode) begin
                        for (int c = 0; c < fscs_pkg::CHANNELS; c++) begin
                            if (r_phase == fscs_pkg::PH_OPEN) begin
                                r_open[c] <= w_lane_avg[c];
                            end else begin
                                r_close[c] <= w_lane_avg[c];
                            end
                        end
                        r_phase    <= (r_phase == fscs_pkg::PH_OPEN) ? fscs_pkg::PH_CLOSE
                                                                    : fscs_pkg::PH_RUN;
                        r_have_ref <= 1'b0;
                        r_good     <= '0;
                    end else begin
                        for (int c = 0; c < fscs_pkg::CHANNELS; c++) begin
                            r_res_angle[c] <= w_lane_angle[c];
                        end
                    end
                    r_state <= S_EMIT;
                end

                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        for (int c = 0; c < fscs_pkg::CHANNELS; c++) begin
                            r_out_angle[c] <= r_res_angle[c];
                        end
                        r_out_phase        <= r_res_phase;
                        r_out_err          <= r_res_err;
                        r_out_angles_valid <= r_res_valid;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_angle_a         = r_out_angle[0];
    assign o_angle_b         = r_out_angle[1];
    assign o_angle_c         = r_out_angle[2];
    assign o_angle_d         = r_out_angle[3];
    assign o_phase_now       = r_out_phase;
    assign o_tolerance_error = r_out_err;
    assign o_angles_valid    = r_out_angles_valid;

endmodule

// File: hdl/fscs_checker.sv
// ============================================================================
// fscs_checker
// Port-level checks of the flex sensor calibrate and scale block.
// ============================================================================
module fscs_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input fscs_pkg::t_angle     o_angle_a,
    input fscs_pkg::t_angle     o_angle_b,
    input fscs_pkg::t_angle     o_angle_c,
    input fscs_pkg::t_angle     o_angle_d,
    input logic [1:0]           o_phase_now,
    input logic                 o_tolerance_error,
    input logic                 o_angles_valid
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result transaction dropped before it was taken");

    // Angles are reported only for sets handled in the run phase.
    a_valid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_angles_valid |-> o_phase_now == fscs_pkg::PH_RUN)
        else $error("angles reported outside the run phase");

    // A tolerance failure only happens during calibration.
    a_err_calib: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tolerance_error |->
            !o_angles_valid &&
            (o_phase_now == fscs_pkg::PH_OPEN || o_phase_now == fscs_pkg::PH_CLOSE))
        else $error("tolerance error flagged outside calibration");

    // Calibration results carry zero angles.
    a_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_angles_valid |->
            o_angle_a == '0 && o_angle_b == '0 && o_angle_c == '0 && o_angle_d == '0)
        else $error("nonzero angle in a calibration result");

endmodule

bind flex_sensor_calibrate_and_scale fscs_checker u_fscs_checker (.*);

// File: bench/angle_checker.sv
// ============================================================================
// angle_checker
// Predicts and checks every result of the calibrate-and-scale block.
// ============================================================================
// Watches the sample set channel, the result channel and the configuration
// port. Each accepted sample set is run through a cycle-free copy of the
// calibration and mapping rules, and each accepted result is compared with
// the oldest prediction still waiting.
// ============================================================================
module angle_checker
    import fscs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  t_sample                  i_chan_a,
    input  t_sample                  i_chan_b,
    input  t_sample                  i_chan_c,
    input  t_sample                  i_chan_d,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  t_angle                   i_angle_a,
    input  t_angle                   i_angle_b,
    input  t_angle                   i_angle_c,
    input  t_angle                   i_angle_d,
    input  logic [1:0]               i_phase_now,
    input  logic                     i_tolerance_error,
    input  logic                     i_angles_valid,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic                     i_pready,
    input  logic [APB_ADDR_BITS-1:0] i_paddr,
    input  logic [APB_DATA_BITS-1:0] i_pwdata,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        t_angle [CHANNELS-1:0] angle;
        logic [1:0]            phase;
        logic                  tol_err;
        logic                  angles_ok;
    } set_result_t;

    logic [TOL_BITS-1:0]    tol_reg;
    t_angle                 amax_reg;
    logic [1:0]             cal_phase;
    logic                   ref_held;
    t_sample [CHANNELS-1:0] ref_sample;
    int unsigned            good_sets;
    t_sum [CHANNELS-1:0]    chan_sum;
    t_sample [CHANNELS-1:0] open_avg;
    t_sample [CHANNELS-1:0] close_avg;
    set_result_t            results_due [$];

    // Linear map with truncation toward zero, then clamped to 0..angle_max.
    function automatic t_angle scale_to_angle(input t_sample x, input t_sample lo,
                                              input t_sample hi);
        longint span;
        longint v;
        span = longint'(hi) - longint'(lo);
        if (span == 0) return '0;
        v = (longint'(x) - longint'(lo)) * longint'(amax_reg) / span;
        if (v < 0) v = 0;
        if (v > longint'(amax_reg)) v = longint'(amax_reg);
        return t_angle'(v);
    endfunction

    function automatic set_result_t predict_set(input t_sample [CHANNELS-1:0] s);
        set_result_t r;
        logic        pass;
        int          d;
        r = '0;
        r.phase = cal_phase;
        if (cal_phase >= PH_RUN) begin
            for (int c = 0; c < CHANNELS; c++)
                r.angle[c] = scale_to_angle(s[c], open_avg[c], close_avg[c]);
            r.angles_ok = 1'b1;
            r.phase = PH_RUN;
        end else if (!ref_held) begin
            ref_sample = s;
            ref_held = 1'b1;
            good_sets = 0;
            chan_sum = '0;
        end else begin
            pass = 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
                d = int'(s[c]) - int'(ref_sample[c]);
                if (d < 0) d = -d;
                if (d >= int'(tol_reg)) pass = 1'b0;
            end
            if (!pass) begin
                r.tol_err = 1'b1;
                ref_held = 1'b0;
                good_sets = 0;
                chan_sum = '0;
            end else begin
                for (int c = 0; c < CHANNELS; c++)
                    chan_sum[c] = chan_sum[c] + t_sum'(s[c]);
                good_sets++;
                if (good_sets >= SAMPLES) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (cal_phase == PH_OPEN) open_avg[c] = t_sample'(chan_sum[c] / SAMPLES);
                        else close_avg[c] = t_sample'(chan_sum[c] / SAMPLES);
                    end
                    cal_phase = (cal_phase == PH_OPEN) ? PH_CLOSE : PH_RUN;
                    ref_held = 1'b0;
                    good_sets = 0;
                    chan_sum = '0;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        set_result_t got;
        set_result_t want;
        if (!i_rst_n) begin
            tol_reg = TOL_RESET;
            amax_reg = AMAX_RESET;
            cal_phase = PH_OPEN;
            ref_held = 1'b0;
            ref_sample = '0;
            good_sets = 0;
            chan_sum = '0;
            open_avg = '0;
            close_avg = '0;
            results_due.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_TOLERANCE) tol_reg = i_pwdata[TOL_BITS-1:0];
                else amax_reg = i_pwdata[ANGLE_BITS-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                got.angle = {i_angle_d, i_angle_c, i_angle_b, i_angle_a};
                got.phase = i_phase_now;
                got.tol_err = i_tolerance_error;
                got.angles_ok = i_angles_valid;
                if (results_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: angles %0d %0d %0d %0d phase %0d",
                                 i_angle_a, i_angle_b, i_angle_c, i_angle_d, i_phase_now);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.angle !== want.angle || got.phase !== want.phase ||
                        got.tol_err !== want.tol_err || got.angles_ok !== want.angles_ok) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch expected: angles %0d %0d %0d %0d phase %0d err %0b valid %0b",
                                     want.angle[0], want.angle[1], want.angle[2], want.angle[3],
                                     want.phase, want.tol_err, want.angles_ok);
                            $display("         actual:   angles %0d %0d %0d %0d phase %0d err %0b valid %0b",
                                     got.angle[0], got.angle[1], got.angle[2], got.angle[3],
                                     got.phase, got.tol_err, got.angles_ok);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                results_due.push_back(predict_set({i_chan_d, i_chan_c, i_chan_b, i_chan_a}));
            o_pending = results_due.size();
        end
    end

endmodule

// File: bench/tb.sv
// ============================================================================
// tb
// Stimulus and verdict for the flex sensor calibrate and scale block.
// ============================================================================
// Walks the block through open calibration, close calibration and the run
// phase, with failing sets and restarts along the way, and writes both
// registers at their extremes while the block is idle. A checker beside the
// block predicts and compares every result; this module drives the channels,
// the register writes and the result handshake, and reports the outcome.
// ============================================================================
module tb;
    import fscs_pkg::*;

    typedef t_sample [CHANNELS-1:0] sample_set_t;

    // Channel c keeps one level through both calibration phases so that its
    // span is zero and every run-phase angle on it must come out as 0.
    localparam int ZERO_SPAN_CHAN = 2;
    // The receiver holds off for a long stretch once the stimulus arms the
    // stall; the sender keeps offering sets so the block backs up.
    localparam int STALL_CYCLES   = 300;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    t_sample                  chan_a = '0;
    t_sample                  chan_b = '0;
    t_sample                  chan_c = '0;
    t_sample                  chan_d = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_angle                   angle_a;
    t_angle                   angle_b;
    t_angle                   angle_c;
    t_angle                   angle_d;
    logic [1:0]               phase_now;
    logic                     tolerance_error;
    logic                     angles_valid;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int fail_count;
    int pending;
    bit stall_armed = 1'b0;
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    flex_sensor_calibrate_and_scale dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_chan_a          (chan_a),
        .i_chan_b          (chan_b),
        .i_chan_c          (chan_c),
        .i_chan_d          (chan_d),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_angle_a         (angle_a),
        .o_angle_b         (angle_b),
        .o_angle_c         (angle_c),
        .o_angle_d         (angle_d),
        .o_phase_now       (phase_now),
        .o_tolerance_error (tolerance_error),
        .o_angles_valid    (angles_valid),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    angle_checker chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_chan_a          (chan_a),
        .i_chan_b          (chan_b),
        .i_chan_c          (chan_c),
        .i_chan_d          (chan_d),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_angle_a         (angle_a),
        .i_angle_b         (angle_b),
        .i_angle_c         (angle_c),
        .i_angle_d         (angle_d),
        .i_phase_now       (phase_now),
        .i_tolerance_error (tolerance_error),
        .i_angles_valid    (angles_valid),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Channel a sits in the lowest bits of a sample set.
    function automatic sample_set_t make_set(input t_sample a, input t_sample b,
                                             input t_sample c, input t_sample d);
        return {d, c, b, a};
    endfunction

    // One random sample over the full converter range.
    function automatic t_sample any_sample();
        return t_sample'($urandom_range(0, 1023));
    endfunction

    // A set that stays within spread of the base on every channel except the
    // zero-span channel, which is left untouched. With spread below the
    // tolerance this set always passes against the base as reference.
    function automatic sample_set_t jitter_set(input sample_set_t base, input int spread);
        sample_set_t s;
        int          v;
        s = base;
        for (int c = 0; c < CHANNELS; c++) begin
            if (c != ZERO_SPAN_CHAN) begin
                v = int'(base[c]) + int'($urandom_range(0, 2 * spread)) - spread;
                if (v < 0) v = 0;
                if (v > 1023) v = 1023;
                s[c] = t_sample'(v);
            end
        end
        return s;
    endfunction

    // A set meant to break the tolerance: either one channel thrown to the far
    // rail, or plain noise on every channel.
    function automatic sample_set_t break_set(input sample_set_t base);
        sample_set_t s;
        int          c;
        s = base;
        c = $urandom_range(0, CHANNELS - 1);
        if ($urandom_range(0, 1) == 0)
            s[c] = (base[c] < 512) ? t_sample'(1023) : t_sample'(0);
        else
            s = make_set(any_sample(), any_sample(), any_sample(), any_sample());
        return s;
    endfunction

    // Offers one sample set after a random gap and waits for the transaction.
    // Now and then the sender switches into a stretch with no gaps at all.
    task automatic send_set(input sample_set_t s);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_eager = !tx_eager;
        gap = tx_eager ? 0 : $urandom_range(0, 18);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        chan_a <= s[0];
        chan_b <= s[1];
        chan_c <= s[2];
        chan_d <= s[3];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stops offering sets until every predicted result has come back, then
    // waits on so that the block is idle for a register write.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [APB_DATA_BITS-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // One calibration phase: a few attempts that pick up a reference, gather
    // some good sets and then break, followed by a clean attempt of a
    // reference and SAMPLES good sets that completes the phase.
    task automatic calibrate(input sample_set_t center, input int spread, input int tries);
        sample_set_t r;
        for (int t = 0; t < tries; t++) begin
            r = jitter_set(center, spread);
            send_set(r);
            repeat ($urandom_range(0, SAMPLES - 1)) send_set(jitter_set(r, spread));
            send_set(break_set(r));
        end
        send_set(center);
        repeat (SAMPLES) send_set(jitter_set(center, spread));
    endtask

    // Run-phase sets over the full sample range, so the map is driven well
    // below the open average and well above the close average too.
    task automatic scale_chunk(input int count);
        repeat (count)
            send_set(make_set(any_sample(), any_sample(), any_sample(), any_sample()));
    endtask

    // Result side: a random hold-off before each transaction, stretches with
    // no hold-off, and one long stall counted here in cycles.
    initial begin : result_sink
        int gap;
        bit stall_done;
        stall_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 29) == 0) rx_eager = !rx_eager;
            gap = rx_eager ? 0 : $urandom_range(0, 18);
            if (stall_armed && !stall_done) begin
                gap = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : stimulus
        sample_set_t open_center;
        sample_set_t close_center;
        t_sample     flat_level;
        int          tol;
        int          waited;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset tolerance of 20. The first set becomes
        // the reference; a deviation of 19 on every channel still passes,
        // while exactly 20 on one channel fails and drops the reference.
        send_set(make_set(0, 1023, 512, 341));
        send_set(make_set(19, 1004, 531, 360));
        send_set(make_set(0, 1023, 512, 361));
        send_set(make_set(1023, 0, 682, 0));
        send_set(make_set(1023, 0, 682, 0));
        send_set(make_set(1002, 0, 682, 0));

        // Widest tolerance: a full-scale swing of 1023 is the only failure.
        settle();
        write_register(REG_TOLERANCE, 1023);
        send_set(make_set(0, 0, 1023, 1023));
        send_set(make_set(1022, 1022, 1, 1));
        send_set(make_set(1023, 0, 1023, 1023));

        // Zero tolerance: even an identical set fails against its reference.
        settle();
        write_register(REG_TOLERANCE, 0);
        send_set(make_set(5, 6, 7, 8));
        send_set(make_set(5, 6, 7, 8));

        // Open calibration with a moderate tolerance and jitter just inside
        // it. Channel a calibrates low-to-high, channel b high-to-low.
        flat_level = any_sample();
        open_center = make_set(t_sample'($urandom_range(0, 300)),
                               t_sample'($urandom_range(700, 1023)),
                               flat_level, any_sample());
        close_center = make_set(t_sample'($urandom_range(700, 1023)),
                                t_sample'($urandom_range(0, 300)),
                                flat_level, any_sample());
        settle();
        tol = $urandom_range(2, 63);
        write_register(REG_TOLERANCE, tol);
        calibrate(open_center, tol - 1, 3);

        // Close calibration at the tightest tolerance that can pass: only
        // exact repeats of the reference get through, so the close averages
        // equal the close center exactly.
        settle();
        write_register(REG_TOLERANCE, 1);
        calibrate(close_center, 0, 2);

        // Run phase at the reset angle_max: rails and both calibration points.
        settle();
        send_set(make_set(0, 0, 0, 0));
        send_set(make_set(1023, 1023, 1023, 1023));
        send_set(open_center);
        send_set(close_center);
        scale_chunk(90);

        // The receiver stalls for a long stretch early in this chunk while
        // sets keep coming.
        settle();
        write_register(REG_ANGLE_MAX, 255);
        send_set(close_center);
        stall_armed = 1'b1;
        scale_chunk(110);

        settle();
        write_register(REG_ANGLE_MAX, 1);
        send_set(close_center);
        scale_chunk(90);

        settle();
        write_register(REG_ANGLE_MAX, 0);
        scale_chunk(20);

        settle();
        write_register(REG_ANGLE_MAX, $urandom_range(2, 254));
        send_set(close_center);
        scale_chunk(130);

        // Drain the block, then leave room for any stray result to show up.
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(negedge clk);
            waited++;
        end
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin : watchdog
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
